// ----- rtl/grfa_pkg.sv -----
package grfa_pkg;

   localparam int FUNC_W  = 2;
   localparam int COORD_W = 6;
   localparam int SIZE_W  = 7;

   localparam logic [FUNC_W-1:0] FUNC_FIND  = 2'd0;
   localparam logic [FUNC_W-1:0] FUNC_FILL  = 2'd1;
   localparam logic [FUNC_W-1:0] FUNC_CLEAR = 2'd2;

   typedef struct packed {
      logic               valid;
      logic               flush;
      logic [COORD_W-1:0] row;
   } win_ctl_type;

   typedef struct packed {
      logic               valid;
      logic               hit;
      logic [COORD_W-1:0] col;
      logic [COORD_W-1:0] row;
   } win_sts_type;

endpackage

// ----- rtl/grfa_req_if.sv -----
interface grfa_req_if import grfa_pkg::*;
();
   logic               valid;
   logic               ready;
   logic [FUNC_W-1:0]  func;
   logic [COORD_W-1:0] origin_col;
   logic [COORD_W-1:0] origin_row;
   logic [SIZE_W-1:0]  req_width;
   logic [SIZE_W-1:0]  req_height;
   logic               mark_used;

   modport source (output valid, func, origin_col, origin_row, req_width, req_height,
                   mark_used, input ready);
   modport sink (input valid, func, origin_col, origin_row, req_width, req_height,
                 mark_used, output ready);
   modport monitor (input valid, ready, func, origin_col, origin_row, req_width,
                    req_height, mark_used);
endinterface

// ----- rtl/grfa_rsp_if.sv -----
interface grfa_rsp_if import grfa_pkg::*;
();
   logic               valid;
   logic               ready;
   logic               found;
   logic [COORD_W-1:0] found_col;
   logic [COORD_W-1:0] found_row;

   modport source (output valid, found, found_col, found_row, input ready);
   modport sink (input valid, found, found_col, found_row, output ready);
   modport monitor (input valid, ready, found, found_col, found_row);
endinterface

// ----- rtl/grfa_window.sv -----
module grfa_window import grfa_pkg::*;
#(
   parameter int GRID_CELLS = 64
)
(
   input  logic                                 clock,
   input  logic                                 reset,
   input  win_ctl_type                          ctl,
   input  logic [GRID_CELLS-1:0]                free,
   input  logic [$clog2(GRID_CELLS + 1)-1:0]    width,
   output win_sts_type                          sts
);

   localparam int CNT_W = $clog2(GRID_CELLS + 1);

   logic [GRID_CELLS:0]   a_ff [CNT_W+1];
   logic [GRID_CELLS-1:0] p_ff [CNT_W+1];
   logic [COORD_W-1:0]    r_ff [CNT_W+1];
   logic [CNT_W:0]        v_ff;
   logic [COORD_W-1:0]    first_col;

   // Stage k joins a run of 2**k free columns onto the window when bit k of the width is set.
   // The extra top bit of the window stands for an empty run that ends on the right edge.
   always_ff @(posedge clock) begin
      if (reset || ctl.flush) begin
         v_ff <= '0;
      end else begin
         v_ff <= {v_ff[CNT_W-1:0], ctl.valid};
      end
      a_ff[0] <= '1;
      p_ff[0] <= free;
      r_ff[0] <= ctl.row;
      for (int k = 0; k < CNT_W; k++) begin
         p_ff[k+1] <= p_ff[k] & (p_ff[k] >> (1 << k));
         a_ff[k+1] <= width[k] ? ((GRID_CELLS+1)'(p_ff[k]) & (a_ff[k] >> (1 << k))) : a_ff[k];
         r_ff[k+1] <= r_ff[k];
      end
   end

   always_comb begin
      first_col = '0;
      for (int c = GRID_CELLS - 1; c >= 0; c--) begin
         if (a_ff[CNT_W][c]) begin
            first_col = COORD_W'(c);
         end
      end
   end

   assign sts.valid = v_ff[CNT_W];
   assign sts.hit   = |a_ff[CNT_W][GRID_CELLS-1:0];
   assign sts.col   = first_col;
   assign sts.row   = r_ff[CNT_W];

endmodule

// ----- rtl/grid_region_first_fit_allocator.sv -----
// Find: one occupancy row is read per cycle and streams through the window pipeline.
// Fill: one read-modify-write per row, over the height clipped to the grid.
// Clear and rejected requests go straight to the response. One transaction is in flight at a time.
// Reset is synchronous and active high; it frees every cell at once through the row valid bits.
module grid_region_first_fit_allocator import grfa_pkg::*;
#(
   parameter int GRID_CELLS = 64
)
(
   input logic         clock,
   input logic         reset,
   grfa_req_if.sink    req,
   grfa_rsp_if.source  rsp
);

   localparam int ROW_AW = $clog2(GRID_CELLS);
   localparam int CNT_W  = $clog2(GRID_CELLS + 1);
   localparam int SUM_W  = SIZE_W + 1;

   typedef enum logic [1:0] {S_IDLE, S_FIND, S_FILL, S_RESP} state_type;

   state_type             state_ff, state_in;
   logic                  rsp_valid_ff, rsp_valid_in;
   logic                  rsp_found_ff, rsp_found_in;
   logic [COORD_W-1:0]    rsp_col_ff, rsp_col_in;
   logic [COORD_W-1:0]    rsp_row_ff, rsp_row_in;
   logic                  res_found_ff, res_found_in;
   logic [COORD_W-1:0]    res_col_ff, res_col_in;
   logic [COORD_W-1:0]    res_row_ff, res_row_in;
   logic [CNT_W-1:0]      w_ff, w_in;
   logic [CNT_W-1:0]      h_ff, h_in;
   logic                  used_ff, used_in;
   logic [GRID_CELLS-1:0] mask_ff, mask_in;
   logic [CNT_W-1:0]      cnt_ff, cnt_in;
   logic [CNT_W-1:0]      end_ff, end_in;
   logic                  pend_ff, pend_in;
   logic [ROW_AW-1:0]     idx_ff, idx_in;
   logic [GRID_CELLS-1:0] vld_ff, vld_in;
   logic [CNT_W-1:0]      run_ff [GRID_CELLS];
   logic [CNT_W-1:0]      run_in [GRID_CELLS];
   logic [CNT_W-1:0]      run_upd [GRID_CELLS];

   logic [GRID_CELLS-1:0] rows_ff [GRID_CELLS];
   logic [GRID_CELLS-1:0] rd_q_ff;
   logic                  rd_vld_ff;

   logic [ROW_AW-1:0]     rd_addr;
   logic                  issuing;
   logic [GRID_CELLS-1:0] row_word;
   logic [GRID_CELLS-1:0] wr_word;
   logic                  wr_en;
   logic [GRID_CELLS-1:0] free_cols;
   logic                  size_bad;
   logic                  fill_skip;
   logic [SUM_W-1:0]      fill_sum;
   logic [CNT_W-1:0]      fill_end;
   logic [GRID_CELLS-1:0] low_mask;
   logic [CNT_W-1:0]      ret_next;
   logic                  push;
   logic [SIZE_W-1:0]     last_origin;
   win_ctl_type           win_ctl;
   win_sts_type           win_sts;

   assign rd_addr  = cnt_ff[ROW_AW-1:0];
   assign issuing  = cnt_ff < end_ff;
   assign row_word = rd_vld_ff ? rd_q_ff : '0;
   assign wr_en    = (state_ff == S_FILL) && pend_ff;
   assign wr_word  = used_ff ? (row_word | mask_ff) : (row_word & ~mask_ff);

   assign size_bad  = (req.req_width == '0) || (req.req_height == '0) ||
                      (req.req_width > SIZE_W'(GRID_CELLS)) ||
                      (req.req_height > SIZE_W'(GRID_CELLS));
   assign fill_skip = (req.req_width == '0) || (req.req_height == '0) ||
                      (SIZE_W'(req.origin_col) >= SIZE_W'(GRID_CELLS)) ||
                      (SIZE_W'(req.origin_row) >= SIZE_W'(GRID_CELLS));
   assign fill_sum  = SUM_W'(req.origin_row) + SUM_W'(req.req_height);
   assign fill_end  = (fill_sum > SUM_W'(GRID_CELLS)) ? CNT_W'(GRID_CELLS) : CNT_W'(fill_sum);
   assign low_mask  = (req.req_width >= SIZE_W'(GRID_CELLS)) ? '1 :
                      ~({GRID_CELLS{1'b1}} << req.req_width);

   assign ret_next    = CNT_W'(idx_ff) + CNT_W'(1);
   assign push        = ret_next >= h_ff;
   assign last_origin = SIZE_W'(GRID_CELLS) - SIZE_W'(h_ff);

   // Per column, the count of free rows ending at the returned row, held at the height.
   always_comb begin
      for (int c = 0; c < GRID_CELLS; c++) begin
         if (row_word[c]) begin
            run_upd[c] = '0;
         end else if (run_ff[c] == h_ff) begin
            run_upd[c] = h_ff;
         end else begin
            run_upd[c] = run_ff[c] + CNT_W'(1);
         end
         free_cols[c] = (run_upd[c] == h_ff);
      end
   end

   always_comb begin
      state_in     = state_ff;
      rsp_valid_in = rsp_valid_ff && !rsp.ready;
      rsp_found_in = rsp_found_ff;
      rsp_col_in   = rsp_col_ff;
      rsp_row_in   = rsp_row_ff;
      res_found_in = res_found_ff;
      res_col_in   = res_col_ff;
      res_row_in   = res_row_ff;
      w_in         = w_ff;
      h_in         = h_ff;
      used_in      = used_ff;
      mask_in      = mask_ff;
      cnt_in       = cnt_ff;
      end_in       = end_ff;
      pend_in      = 1'b0;
      idx_in       = idx_ff;
      vld_in       = vld_ff;
      run_in       = run_ff;

      unique case (state_ff)
         S_IDLE: begin
            if (req.valid) begin
               res_found_in = 1'b0;
               res_col_in   = '0;
               res_row_in   = '0;
               state_in     = S_RESP;
               unique case (req.func)
                  FUNC_FIND: begin
                     if (!size_bad) begin
                        w_in     = CNT_W'(req.req_width);
                        h_in     = CNT_W'(req.req_height);
                        cnt_in   = '0;
                        end_in   = CNT_W'(GRID_CELLS);
                        state_in = S_FIND;
                        for (int c = 0; c < GRID_CELLS; c++) begin
                           run_in[c] = '0;
                        end
                     end
                  end
                  FUNC_FILL: begin
                     res_found_in = 1'b1;
                     if (!fill_skip) begin
                        cnt_in   = CNT_W'(req.origin_row);
                        end_in   = fill_end;
                        mask_in  = low_mask << req.origin_col;
                        used_in  = req.mark_used;
                        state_in = S_FILL;
                     end
                  end
                  FUNC_CLEAR: begin
                     res_found_in = 1'b1;
                     vld_in       = '0;
                  end
                  default: begin
                     res_found_in = 1'b0;
                  end
               endcase
            end
         end
         S_FIND: begin
            if (issuing) begin
               cnt_in = cnt_ff + CNT_W'(1);
            end
            pend_in = issuing;
            idx_in  = rd_addr;
            if (pend_ff) begin
               run_in = run_upd;
            end
            if (win_sts.valid) begin
               if (win_sts.hit) begin
                  res_found_in = 1'b1;
                  res_col_in   = win_sts.col;
                  res_row_in   = win_sts.row;
                  state_in     = S_RESP;
                  pend_in      = 1'b0;
               end else if (SIZE_W'(win_sts.row) == last_origin) begin
                  res_found_in = 1'b0;
                  res_col_in   = '0;
                  res_row_in   = '0;
                  state_in     = S_RESP;
                  pend_in      = 1'b0;
               end
            end
         end
         S_FILL: begin
            if (issuing) begin
               cnt_in = cnt_ff + CNT_W'(1);
            end
            pend_in = issuing;
            idx_in  = rd_addr;
            if (pend_ff) begin
               vld_in[idx_ff] = 1'b1;
            end
            if (!issuing && !pend_ff) begin
               state_in = S_RESP;
            end
         end
         S_RESP: begin
            if (!rsp_valid_ff || rsp.ready) begin
               rsp_valid_in = 1'b1;
               rsp_found_in = res_found_ff;
               rsp_col_in   = res_col_ff;
               rsp_row_in   = res_row_ff;
               state_in     = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         rsp_valid_ff <= 1'b0;
         pend_ff      <= 1'b0;
         vld_ff       <= '0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
         pend_ff      <= pend_in;
         vld_ff       <= vld_in;
      end
      rsp_found_ff <= rsp_found_in;
      rsp_col_ff   <= rsp_col_in;
      rsp_row_ff   <= rsp_row_in;
      res_found_ff <= res_found_in;
      res_col_ff   <= res_col_in;
      res_row_ff   <= res_row_in;
      w_ff         <= w_in;
      h_ff         <= h_in;
      used_ff      <= used_in;
      mask_ff      <= mask_in;
      cnt_ff       <= cnt_in;
      end_ff       <= end_in;
      idx_ff       <= idx_in;
      run_ff       <= run_in;
   end

   always_ff @(posedge clock) begin
      if (wr_en) begin
         rows_ff[idx_ff] <= wr_word;
      end
      rd_q_ff   <= rows_ff[rd_addr];
      rd_vld_ff <= vld_ff[rd_addr];
   end

   assign win_ctl.valid = (state_ff == S_FIND) && pend_ff && push;
   assign win_ctl.flush = (state_in != S_FIND);
   assign win_ctl.row   = COORD_W'(ret_next - h_ff);

   grfa_window #(
      .GRID_CELLS (GRID_CELLS)
   ) u_window (
      .clock (clock),
      .reset (reset),
      .ctl   (win_ctl),
      .free  (free_cols),
      .width (w_ff),
      .sts   (win_sts)
   );

   assign req.ready     = (state_ff == S_IDLE);
   assign rsp.valid     = rsp_valid_ff;
   assign rsp.found     = rsp_found_ff;
   assign rsp.found_col = rsp_col_ff;
   assign rsp.found_row = rsp_row_ff;

endmodule

// ----- rtl/grfa_checker.sv -----
module grfa_checker import grfa_pkg::*;
(
   input logic         clock,
   input logic         reset,
   grfa_req_if.sink    req,
   grfa_rsp_if.source  rsp
);

   // After reset the block is empty and ready for a transaction.
   assert property (@(posedge clock) reset |=> !rsp.valid && req.ready)
      else $error("block not idle after reset");

   // An accepted transaction closes the request side in the following cycle.
   assert property (@(posedge clock) disable iff (reset)
      req.valid && req.ready |=> !req.ready)
      else $error("request accepted while a transaction is in progress");

   // A new response is only raised from a state in which the request side is closed.
   assert property (@(posedge clock) disable iff (reset)
      $rose(rsp.valid) |-> $past(!req.ready))
      else $error("response without a transaction");

   // A miss reports the origin as zero.
   assert property (@(posedge clock) disable iff (reset)
      rsp.valid && !rsp.found |-> rsp.found_col == '0 && rsp.found_row == '0)
      else $error("miss with a nonzero origin");

   assert property (@(posedge clock) disable iff (reset)
      rsp.valid && !rsp.ready |=> rsp.valid && $stable(rsp.found) &&
         $stable(rsp.found_col) && $stable(rsp.found_row))
      else $error("stalled response changed");

endmodule

bind grid_region_first_fit_allocator grfa_checker u_grfa_checker (
   .clock (clock),
   .reset (reset),
   .req   (req),
   .rsp   (rsp)
);

// ----- verif/testbench.sv -----
`timescale 1ns / 1ps

module testbench;
   import grfa_pkg::*;

   localparam logic [FUNC_W-1:0] FUNC_UNUSED = 2'd3;
   localparam int GRID           = 64;
   localparam int WATCHDOG_LIMIT = 4000;
   localparam int DRAIN_CYCLES   = 100;
   localparam int PHASE_ITEMS    = 250;
   localparam int PRINT_LIMIT    = 40;

   typedef struct packed {
      logic [FUNC_W-1:0]  func;
      logic [COORD_W-1:0] col;
      logic [COORD_W-1:0] row;
      logic [SIZE_W-1:0]  width;
      logic [SIZE_W-1:0]  height;
      logic               used;
      logic               at_last_fit;
   } alloc_req_type;

   typedef struct packed {
      logic               found;
      logic [COORD_W-1:0] col;
      logic [COORD_W-1:0] row;
   } alloc_rsp_type;

   logic clock = 1'b0;
   logic reset = 1'b1;

   logic          drv_valid  = 1'b0;
   alloc_req_type drv_item   = '0;
   logic          sink_ready = 1'b0;

   grfa_req_if req_ch();
   grfa_rsp_if rsp_ch();

   assign req_ch.valid      = drv_valid;
   assign req_ch.func       = drv_item.func;
   assign req_ch.origin_col = drv_item.col;
   assign req_ch.origin_row = drv_item.row;
   assign req_ch.req_width  = drv_item.width;
   assign req_ch.req_height = drv_item.height;
   assign req_ch.mark_used  = drv_item.used;
   assign rsp_ch.ready      = sink_ready;

   grid_region_first_fit_allocator #(.GRID_CELLS(GRID)) dut (
      .clock (clock),
      .reset (reset),
      .req   (req_ch),
      .rsp   (rsp_ch)
   );

   logic [GRID-1:0] occupancy [GRID] = '{default: '0};
   alloc_req_type   pending_requests [$];
   alloc_rsp_type   expected_fits [$];
   alloc_rsp_type   last_fit = '0;

   int send_idle_pct  = 0;
   int recv_stall_pct = 0;
   int idle_cycles    = 0;
   int n_errors       = 0;
   int n_accepted     = 0;
   int n_checked      = 0;
   int n_finds        = 0;
   int n_hits         = 0;
   int n_fills        = 0;
   int n_clears       = 0;
   int n_unused       = 0;

   initial begin
      forever #5 clock = ~clock;
   end

   function automatic logic [GRID-1:0] ones_below(int n);
      logic [GRID-1:0] one;
      one = GRID'(1);
      if (n >= GRID) begin
         return '1;
      end
      return (one << n) - GRID'(1);
   endfunction

   function automatic alloc_rsp_type first_fit(int w, int h);
      alloc_rsp_type   fit;
      logic [GRID-1:0] span;
      logic [GRID-1:0] merged;
      fit = '0;
      if (w == 0 || h == 0 || w > GRID || h > GRID) begin
         return fit;
      end
      span = ones_below(w);
      for (int r = 0; r + h <= GRID; r++) begin
         merged = '0;
         for (int k = 0; k < h; k++) begin
            merged |= occupancy[r + k];
         end
         for (int c = 0; c + w <= GRID; c++) begin
            if ((merged & (span << c)) == '0) begin
               fit.found = 1'b1;
               fit.col   = COORD_W'(c);
               fit.row   = COORD_W'(r);
               return fit;
            end
         end
      end
      return fit;
   endfunction

   function automatic void fill_cells(int col, int row, int w, int h, logic used);
      logic [GRID-1:0] mask;
      int              last;
      if (w == 0 || h == 0) begin
         return;
      end
      mask = ones_below(w) << col;
      last = (row + h > GRID) ? GRID : row + h;
      for (int r = row; r < last; r++) begin
         if (used) begin
            occupancy[r] |= mask;
         end else begin
            occupancy[r] &= ~mask;
         end
      end
   endfunction

   function automatic alloc_rsp_type allocator_response(alloc_req_type t);
      alloc_rsp_type res;
      res = '0;
      case (t.func)
         FUNC_FIND: begin
            res = first_fit(int'(t.width), int'(t.height));
            n_finds++;
            if (res.found) begin
               n_hits++;
            end
         end
         FUNC_FILL: begin
            fill_cells(int'(t.col), int'(t.row), int'(t.width), int'(t.height), t.used);
            res.found = 1'b1;
            n_fills++;
         end
         FUNC_CLEAR: begin
            for (int r = 0; r < GRID; r++) begin
               occupancy[r] = '0;
            end
            res.found = 1'b1;
            n_clears++;
         end
         default: begin
            n_unused++;
         end
      endcase
      return res;
   endfunction

   task automatic report_mismatch(string field, int got, int want);
      n_errors++;
      if (n_errors <= PRINT_LIMIT) begin
         $display("ERROR at %0t ns: %s is %0d, expected %0d", $time, field, got, want);
      end
   endtask

   always @(posedge clock) begin : driver
      alloc_req_type next;
      alloc_rsp_type fit;
      if (reset) begin
         drv_valid <= 1'b0;
      end else begin
         if (drv_valid && req_ch.ready) begin
            fit = allocator_response(drv_item);
            expected_fits.push_back(fit);
            n_accepted++;
            if (drv_item.func == FUNC_FIND) begin
               last_fit = fit;
            end
         end
         if (!drv_valid || req_ch.ready) begin
            if (pending_requests.size() != 0 && $urandom_range(0, 99) >= send_idle_pct) begin
               next = pending_requests.pop_front();
               if (next.at_last_fit) begin
                  next.col = last_fit.col;
                  next.row = last_fit.row;
               end
               drv_item  <= next;
               drv_valid <= 1'b1;
            end else begin
               drv_valid <= 1'b0;
            end
         end
      end
   end

   always @(posedge clock) begin
      if (reset) begin
         sink_ready <= 1'b0;
      end else begin
         sink_ready <= ($urandom_range(0, 99) >= recv_stall_pct);
      end
   end

   always @(posedge clock) begin : monitor
      alloc_rsp_type want;
      if (!reset && rsp_ch.valid && sink_ready) begin
         if (expected_fits.size() == 0) begin
            report_mismatch("unexpected response, found", int'(rsp_ch.found), 0);
         end else begin
            want = expected_fits.pop_front();
            n_checked++;
            if (rsp_ch.found !== want.found) begin
               report_mismatch("found", int'(rsp_ch.found), int'(want.found));
            end
            if (rsp_ch.found_col !== want.col) begin
               report_mismatch("found_col", int'(rsp_ch.found_col), int'(want.col));
            end
            if (rsp_ch.found_row !== want.row) begin
               report_mismatch("found_row", int'(rsp_ch.found_row), int'(want.row));
            end
         end
      end
   end

   always @(posedge clock) begin
      if (reset || (drv_valid && req_ch.ready) || (rsp_ch.valid && sink_ready)) begin
         idle_cycles <= 0;
      end else begin
         idle_cycles <= idle_cycles + 1;
         if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("Watchdog: no transaction for %0d cycles", idle_cycles);
            $display("Some tests failed");
            $finish;
         end
      end
   end

   function automatic alloc_req_type make_req(logic [FUNC_W-1:0] func, int col, int row,
                                              int w, int h, logic used);
      alloc_req_type t;
      t.func        = func;
      t.col         = COORD_W'(col);
      t.row         = COORD_W'(row);
      t.width       = SIZE_W'(w);
      t.height      = SIZE_W'(h);
      t.used        = used;
      t.at_last_fit = 1'b0;
      return t;
   endfunction

   function automatic int rand_size();
      int p;
      p = $urandom_range(0, 99);
      if (p < 55) begin
         return $urandom_range(1, 8);
      end else if (p < 80) begin
         return $urandom_range(1, 20);
      end else if (p < 93) begin
         return $urandom_range(21, 64);
      end else if (p < 96) begin
         return 0;
      end
      return $urandom_range(65, 127);
   endfunction

   task automatic add_random_traffic(int count);
      int            made;
      int            p;
      int            w;
      int            h;
      alloc_req_type t;
      made = 0;
      while (made < count) begin
         p = $urandom_range(0, 99);
         if (p < 35) begin
            // Allocation: a find followed by a fill placed at the position it returns.
            w = $urandom_range(1, 12);
            h = $urandom_range(1, 12);
            pending_requests.push_back(make_req(FUNC_FIND, $urandom_range(0, 63),
                                                $urandom_range(0, 63), w, h,
                                                1'($urandom_range(0, 1))));
            t = make_req(FUNC_FILL, 0, 0, w, h, 1'b1);
            t.at_last_fit = 1'b1;
            pending_requests.push_back(t);
            made += 2;
         end else begin
            if (p < 58) begin
               t = make_req(FUNC_FIND, $urandom_range(0, 63), $urandom_range(0, 63),
                            rand_size(), rand_size(), 1'($urandom_range(0, 1)));
            end else if (p < 85) begin
               t = make_req(FUNC_FILL, $urandom_range(0, 63), $urandom_range(0, 63),
                            rand_size(), rand_size(), $urandom_range(0, 99) < 55);
            end else if (p < 86) begin
               t = make_req(FUNC_CLEAR, $urandom_range(0, 63), $urandom_range(0, 63),
                            $urandom_range(0, 127), $urandom_range(0, 127),
                            1'($urandom_range(0, 1)));
            end else if (p < 89) begin
               t = make_req(FUNC_UNUSED, $urandom_range(0, 63), $urandom_range(0, 63),
                            $urandom_range(0, 127), $urandom_range(0, 127),
                            1'($urandom_range(0, 1)));
            end else begin
               t = make_req(FUNC_FIND, $urandom_range(0, 63), $urandom_range(0, 63),
                            $urandom_range(0, 127), $urandom_range(0, 127),
                            1'($urandom_range(0, 1)));
            end
            pending_requests.push_back(t);
            made++;
         end
      end
   endtask

   task automatic wait_drained();
      while (pending_requests.size() != 0 || drv_valid || expected_fits.size() != 0) begin
         @(posedge clock);
      end
   endtask

   initial begin : stimulus
      int send_pct [4];
      int recv_pct [4];
      send_pct = '{0, 68, 0, 17};
      recv_pct = '{0, 0, 68, 17};
      repeat (3) @(posedge clock);
      reset <= 1'b0;

      pending_requests.push_back(make_req(FUNC_CLEAR, 0, 0, 0, 0, 1'b0));
      pending_requests.push_back(make_req(FUNC_FIND, 0, 0, 1, 1, 1'b0));
      pending_requests.push_back(make_req(FUNC_FIND, 0, 0, 64, 64, 1'b0));
      pending_requests.push_back(make_req(FUNC_FIND, 5, 5, 0, 3, 1'b1));
      pending_requests.push_back(make_req(FUNC_FIND, 5, 5, 3, 65, 1'b0));
      pending_requests.push_back(make_req(FUNC_FIND, 63, 63, 127, 127, 1'b1));
      pending_requests.push_back(make_req(FUNC_FILL, 0, 0, 64, 64, 1'b1));
      pending_requests.push_back(make_req(FUNC_FIND, 0, 0, 1, 1, 1'b0));
      pending_requests.push_back(make_req(FUNC_FILL, 63, 63, 1, 1, 1'b0));
      pending_requests.push_back(make_req(FUNC_FIND, 0, 0, 1, 1, 1'b0));
      pending_requests.push_back(make_req(FUNC_FILL, 60, 62, 127, 127, 1'b0));
      pending_requests.push_back(make_req(FUNC_FIND, 0, 0, 4, 2, 1'b0));
      pending_requests.push_back(make_req(FUNC_FILL, 0, 0, 0, 5, 1'b0));
      pending_requests.push_back(make_req(FUNC_FILL, 0, 0, 5, 0, 1'b0));
      pending_requests.push_back(make_req(FUNC_FIND, 0, 0, 1, 1, 1'b0));
      pending_requests.push_back(make_req(FUNC_UNUSED, 63, 63, 127, 127, 1'b1));
      pending_requests.push_back(make_req(FUNC_FIND, 0, 0, 2, 1, 1'b0));
      pending_requests.push_back(make_req(FUNC_CLEAR, 63, 63, 127, 127, 1'b1));
      pending_requests.push_back(make_req(FUNC_FILL, 0, 0, 64, 1, 1'b1));
      pending_requests.push_back(make_req(FUNC_FIND, 0, 0, 64, 63, 1'b0));
      pending_requests.push_back(make_req(FUNC_FIND, 0, 0, 64, 64, 1'b0));
      pending_requests.push_back(make_req(FUNC_FILL, 32, 10, 1, 64, 1'b1));
      pending_requests.push_back(make_req(FUNC_FIND, 0, 0, 32, 63, 1'b0));
      pending_requests.push_back(make_req(FUNC_FIND, 0, 0, 33, 1, 1'b0));
      pending_requests.push_back(make_req(FUNC_FIND, 0, 0, 64, 1, 1'b0));
      wait_drained();

      for (int ph = 0; ph < 4; ph++) begin
         send_idle_pct  = send_pct[ph];
         recv_stall_pct = recv_pct[ph];
         add_random_traffic(PHASE_ITEMS);
         wait_drained();
      end

      repeat (DRAIN_CYCLES) @(posedge clock);
      if (expected_fits.size() != 0) begin
         report_mismatch("responses still outstanding", 0, expected_fits.size());
      end
      $display("Ran %0d requests: %0d finds (%0d hits), %0d fills, %0d clears, %0d unused codes.",
               n_accepted, n_finds, n_hits, n_fills, n_clears, n_unused);
      $display("Checked %0d responses across four idling phases with %0d mismatches.",
               n_checked, n_errors);
      if (n_errors == 0) begin
         $display("All tests passed");
      end else begin
         $display("Some tests failed");
      end
      $finish;
   end

endmodule

// ----- grid_region_first_fit_allocator.f -----
rtl/grfa_pkg.sv
rtl/grfa_req_if.sv
rtl/grfa_rsp_if.sv
rtl/grfa_window.sv
rtl/grid_region_first_fit_allocator.sv
rtl/grfa_checker.sv
verif/testbench.sv
